>>> sv/tcp_pkg.sv
// Shared types, constants and the fixed-point to byte conversion for the
// tensor channel preview block. No dependencies.
`timescale 1ns / 1ps

package tcp_pkg;

	localparam int MAX_PANEL_DIM  = 640;
	localparam int MAX_TENSOR_DIM = 4096;

	// Field and state widths
	localparam int TDIM_W  = 13;
	localparam int PDIM_W  = 10;
	localparam int SRC_W   = 12;
	localparam int ACC_W   = 22;
	localparam int VAL_W   = 16;
	localparam int BYTE_W  = 8;
	localparam int COL_W   = 12;
	localparam int ROW_W   = 10;
	localparam int CFG_W   = 13;
	localparam int CIDX_W  = 2;
	localparam int SDATA_W = 48;
	localparam int MDATA_W = 48;

	localparam logic [TDIM_W-1:0] TDIM_MAX = TDIM_W'(MAX_TENSOR_DIM);
	localparam logic [PDIM_W-1:0] PDIM_MAX = PDIM_W'(MAX_PANEL_DIM);

	// Configuration register indexes
	typedef enum logic [CIDX_W-1:0] {
		REG_TENSOR_WIDTH  = 2'd0,
		REG_TENSOR_HEIGHT = 2'd1,
		REG_PANEL_WIDTH   = 2'd2,
		REG_PANEL_HEIGHT  = 2'd3
	} reg_idx_t;

	// Preview panel emitted for one picked position, in output order
	typedef enum logic [1:0] {
		PANEL_RGB   = 2'd0,
		PANEL_RED   = 2'd1,
		PANEL_GREEN = 2'd2,
		PANEL_BLUE  = 2'd3
	} panel_t;

	typedef struct packed {
		logic [TDIM_W-1:0] tensor_width;
		logic [TDIM_W-1:0] tensor_height;
		logic [PDIM_W-1:0] panel_width;
		logic [PDIM_W-1:0] panel_height;
	} cfg_t;

	// Outcome of the position scan for the current word
	typedef struct packed {
		logic              hit;
		logic [PDIM_W-1:0] panel_col;
		logic [PDIM_W-1:0] panel_row;
		logic [PDIM_W-1:0] panel_w;
	} pick_t;

	// floor(v*255/4096 + 1/2), clamped to 0..255
	function automatic logic [BYTE_W-1:0] to_byte(input logic signed [VAL_W-1:0] v);
		logic signed [24:0] t;
		logic [12:0]        q;
		t = (25'(v) <<< 8) - 25'(v) + 25'sd2048;
		q = t[24:12];
		if (t[24])
			return '0;
		else if (q > 13'd255)
			return 8'd255;
		else
			return q[BYTE_W-1:0];
	endfunction

endpackage

>>> sv/tcp_scan.sv
// Position scanner: source and panel counters with addition-only accumulators
// that pick nearest-neighbour positions. Depends on tcp_pkg.
`timescale 1ns / 1ps

module tcp_scan (
	input  logic          clk,
	input  logic          arst_n,
	input  tcp_pkg::cfg_t cfg,
	input  logic          clear,
	input  logic          step,
	output tcp_pkg::pick_t pick
);
	import tcp_pkg::*;

	logic [SRC_W-1:0]  src_col_q, src_row_q, src_col_d, src_row_d;
	logic [PDIM_W-1:0] pan_col_q, pan_row_q, pan_col_d, pan_row_d;
	logic [ACC_W-1:0]  ct_q, rt_q, cs_q, rs_q, ct_d, rt_d, cs_d, rs_d;
	logic [TDIM_W-1:0] w, h;
	logic [PDIM_W-1:0] pw_c, ph_c, pw, ph;
	logic [ACC_W:0]    cs_end, rs_end;
	logic              col_hit, row_hit;

	// Clamp the dimensions in use
	always_comb begin
		w    = (cfg.tensor_width == '0) ? TDIM_W'(1) :
		       (cfg.tensor_width > TDIM_MAX) ? TDIM_MAX : cfg.tensor_width;
		h    = (cfg.tensor_height == '0) ? TDIM_W'(1) :
		       (cfg.tensor_height > TDIM_MAX) ? TDIM_MAX : cfg.tensor_height;
		pw_c = (cfg.panel_width == '0) ? PDIM_W'(1) :
		       (cfg.panel_width > PDIM_MAX) ? PDIM_MAX : cfg.panel_width;
		ph_c = (cfg.panel_height == '0) ? PDIM_W'(1) :
		       (cfg.panel_height > PDIM_MAX) ? PDIM_MAX : cfg.panel_height;
		pw   = (TDIM_W'(pw_c) > w) ? w[PDIM_W-1:0] : pw_c;
		ph   = (TDIM_W'(ph_c) > h) ? h[PDIM_W-1:0] : ph_c;
	end

	// Hit when the panel target falls inside this source cell
	always_comb begin
		cs_end  = {1'b0, cs_q} + (ACC_W+1)'(pw);
		rs_end  = {1'b0, rs_q} + (ACC_W+1)'(ph);
		col_hit = (pan_col_q < pw) && (ct_q >= cs_q) && ({1'b0, ct_q} < cs_end);
		row_hit = (pan_row_q < ph) && (rt_q >= rs_q) && ({1'b0, rt_q} < rs_end);
	end

	assign pick = '{hit: col_hit && row_hit, panel_col: pan_col_q,
	                panel_row: pan_row_q, panel_w: pw};

	// Restart the counters on clear, else advance them for one word
	always_comb begin
		src_col_d = src_col_q;
		src_row_d = src_row_q;
		pan_col_d = pan_col_q;
		pan_row_d = pan_row_q;
		ct_d = ct_q;
		rt_d = rt_q;
		cs_d = cs_q;
		rs_d = rs_q;
		if (clear) begin
			src_col_d = '0; src_row_d = '0; pan_col_d = '0; pan_row_d = '0;
			ct_d = '0; rt_d = '0; cs_d = '0; rs_d = '0;
		end else if (step) begin
			if (col_hit) begin
				pan_col_d = pan_col_q + 1'b1;
				ct_d      = ct_q + ACC_W'(w);
			end
			if (TDIM_W'(src_col_q) + 1'b1 < w) begin
				src_col_d = src_col_q + 1'b1;
				cs_d      = cs_q + ACC_W'(pw);
			end else begin
				src_col_d = '0;
				cs_d      = '0;
				pan_col_d = '0;
				ct_d      = '0;
				if (row_hit) begin
					pan_row_d = pan_row_q + 1'b1;
					rt_d      = rt_q + ACC_W'(h);
				end
				if (TDIM_W'(src_row_q) + 1'b1 < h) begin
					src_row_d = src_row_q + 1'b1;
					rs_d      = rs_q + ACC_W'(ph);
				end else begin
					src_row_d = '0; pan_row_d = '0; rt_d = '0; rs_d = '0;
				end
			end
		end
	end

	// Hold the scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_col_q <= '0; src_row_q <= '0; pan_col_q <= '0; pan_row_q <= '0;
			ct_q <= '0; rt_q <= '0; cs_q <= '0; rs_q <= '0;
		end else begin
			src_col_q <= src_col_d; src_row_q <= src_row_d;
			pan_col_q <= pan_col_d; pan_row_q <= pan_row_d;
			ct_q <= ct_d; rt_q <= rt_d; cs_q <= cs_d; rs_q <= rs_d;
		end
	end

endmodule

>>> sv/tensor_channel_preview.sv
// Top level of the tensor channel preview: configuration registers, picked
// word stage and output register. Depends on tcp_pkg and tcp_scan.
`timescale 1ns / 1ps
//
// Usage
//   Slave stream: one word per tensor position in raster order, carrying the
//   red, green and blue values in signed Q4.12. Master stream: preview pixels.
//   An unpicked position is taken, leaves the emit stage free, yields nothing.
//   A picked position yields four pixels (RGB panel, then R, G and B panels
//   side by side); tlast marks the fourth.
//   A picked word is registered in the emit stage on acceptance; each pixel
//   then passes through the output register. Throughput: one pixel per cycle
//   while the receiver does not stall; the next word is taken in the cycle its
//   last pixel moves into the output register.
//   Configuration: plain writes, only while idle; any write restarts the frame.
//   Reset: registers return to 224, scan state to the first position, both
//   streams empty. A stalled receiver holds the output register and, through
//   it, the emit stage and then tready.
//
module tensor_channel_preview (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [tcp_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [tcp_pkg::CFG_W-1:0]   cfg_wdata,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// red_value[15:0], green_value[31:16], blue_value[47:32]
	input  logic [tcp_pkg::SDATA_W-1:0] s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// out_col[11:0], out_row[21:12], red_byte[29:22], green_byte[37:30],
	// blue_byte[45:38], zero fill [47:46]
	output logic [tcp_pkg::MDATA_W-1:0] m_tdata,
	output logic                        m_tlast
);
	import tcp_pkg::*;

	cfg_t              cfg_q;
	pick_t             pick;
	logic              accept, load_out, s1_done;
	logic              s1_valid_q;
	panel_t            k_q;
	logic [BYTE_W-1:0] red_s1, green_s1, blue_s1;
	logic [PDIM_W-1:0] pcol_s1, prow_s1, pw_s1;
	logic              out_valid_q, out_last_q;
	logic [MDATA_W-1:0] out_data_q;
	logic [COL_W-1:0]  px_col;
	logic [BYTE_W-1:0] px_red, px_green, px_blue;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{tensor_width: 13'd224, tensor_height: 13'd224,
			           panel_width: 10'd224, panel_height: 10'd224};
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_TENSOR_WIDTH:  cfg_q.tensor_width  <= cfg_wdata;
				REG_TENSOR_HEIGHT: cfg_q.tensor_height <= cfg_wdata;
				REG_PANEL_WIDTH:   cfg_q.panel_width   <= cfg_wdata[PDIM_W-1:0];
				REG_PANEL_HEIGHT:  cfg_q.panel_height  <= cfg_wdata[PDIM_W-1:0];
				default:           cfg_q <= cfg_q;
			endcase
		end
	end

	tcp_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.clear  (cfg_we),
		.step   (accept),
		.pick   (pick)
	);

	// Handshake between the slave side, the emit stage and the output register
	assign load_out = s1_valid_q && (!out_valid_q || m_tready);
	assign s1_done  = load_out && (k_q == PANEL_BLUE);
	assign s_tready = !s1_valid_q || s1_done;
	assign accept   = s_tvalid && s_tready;

	// Hold a picked word while its four pixels go out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			k_q        <= PANEL_RGB;
		end else begin
			if (accept)
				s1_valid_q <= pick.hit;
			else if (s1_done)
				s1_valid_q <= 1'b0;
			if (accept)
				k_q <= PANEL_RGB;
			else if (load_out)
				k_q <= panel_t'(k_q + 2'd1);
		end
	end

	// Convert the channels as the word is taken
	always_ff @(posedge clk) begin
		if (accept) begin
			red_s1   <= to_byte(s_tdata[15:0]);
			green_s1 <= to_byte(s_tdata[31:16]);
			blue_s1  <= to_byte(s_tdata[47:32]);
			pcol_s1  <= pick.panel_col;
			prow_s1  <= pick.panel_row;
			pw_s1    <= pick.panel_w;
		end
	end

	// Build the pixel of the current panel
	always_comb begin
		px_col = COL_W'(pcol_s1)
		       + (k_q[0] ? COL_W'(pw_s1) : '0)
		       + (k_q[1] ? (COL_W'(pw_s1) << 1) : '0);
		px_red   = (k_q == PANEL_RGB || k_q == PANEL_RED)   ? red_s1   : '0;
		px_green = (k_q == PANEL_RGB || k_q == PANEL_GREEN) ? green_s1 : '0;
		px_blue  = (k_q == PANEL_RGB || k_q == PANEL_BLUE)  ? blue_s1  : '0;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
			out_last_q  <= (k_q == PANEL_BLUE);
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out)
			out_data_q <= {2'b00, px_blue, px_green, px_red, prow_s1[ROW_W-1:0], px_col};
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

	// A picked word starts at the RGB panel
	a_pick_loads: assert property (@(posedge clk) disable iff (!arst_n)
		accept && pick.hit |=> s1_valid_q && k_q == PANEL_RGB)
		else $error("picked word not loaded into emit stage");

	// The panel index only moves while a word is held
	a_panel_held: assert property (@(posedge clk) disable iff (!arst_n)
		k_q != PANEL_RGB |-> s1_valid_q)
		else $error("panel index without a held word");

	// A word is kept until its blue panel leaves
	a_no_early_free: assert property (@(posedge clk) disable iff (!arst_n)
		load_out && k_q != PANEL_BLUE |=> s1_valid_q)
		else $error("word dropped before fourth pixel");

	// The fourth pixel carries tlast
	a_last_marked: assert property (@(posedge clk) disable iff (!arst_n)
		s1_done |=> m_tvalid && m_tlast)
		else $error("fourth pixel not marked last");

endmodule

>>> tb/tcp_checker.sv
// Scoreboard for the tensor channel preview: follows register writes and accepted
// tensor words, works out the preview pixels due and compares the output stream.
// Depends on tcp_pkg for widths, register indexes and panel codes.
`timescale 1ns / 1ps

module tcp_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [tcp_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [tcp_pkg::CFG_W-1:0]   cfg_wdata,
	input  logic                        s_tvalid,
	input  logic                        s_tready,
	input  logic [tcp_pkg::SDATA_W-1:0] s_tdata,
	input  logic                        m_tvalid,
	input  logic                        m_tready,
	input  logic [tcp_pkg::MDATA_W-1:0] m_tdata,
	input  logic                        m_tlast,
	output int                          pending,
	output int                          fail_count
);
	import tcp_pkg::*;

	typedef struct {
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
		logic [BYTE_W-1:0] red;
		logic [BYTE_W-1:0] green;
		logic [BYTE_W-1:0] blue;
		logic              last;
	} preview_px_t;

	preview_px_t pixels_due[$];
	int          errors;

	// Own copy of the registers and the scan position
	logic [TDIM_W-1:0] reg_tw, reg_th;
	logic [PDIM_W-1:0] reg_pw, reg_ph;
	logic [SRC_W-1:0]  src_col, src_row;
	logic [PDIM_W-1:0] pan_col, pan_row;
	logic [ACC_W-1:0]  col_tgt, row_tgt, col_src, row_src;

	function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
		if (v < 1)
			return 1;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// Q4.12 to byte with rounding and saturation
	function automatic logic [BYTE_W-1:0] chan_byte(input logic signed [VAL_W-1:0] v);
		int t;
		t = int'(v) * 255 + 2048;
		if (t < 0)
			return '0;
		if ((t >>> 12) > 255)
			return 8'd255;
		return BYTE_W'(t >>> 12);
	endfunction

	task automatic restart_frame();
		src_col = '0;
		src_row = '0;
		pan_col = '0;
		pan_row = '0;
		col_tgt = '0;
		row_tgt = '0;
		col_src = '0;
		row_src = '0;
	endtask

	// Decide whether this position is picked, queue its four pixels, advance the scan
	task automatic scan_position(input logic [SDATA_W-1:0] d);
		int unsigned       w, h, pw, ph;
		logic              col_hit, row_hit;
		logic [BYTE_W-1:0] rb, gb, bb;
		preview_px_t       px;
		panel_t            pnl;
		w  = clamp_dim(reg_tw, MAX_TENSOR_DIM);
		h  = clamp_dim(reg_th, MAX_TENSOR_DIM);
		pw = clamp_dim(reg_pw, MAX_PANEL_DIM);
		ph = clamp_dim(reg_ph, MAX_PANEL_DIM);
		if (pw > w)
			pw = w;
		if (ph > h)
			ph = h;
		col_hit = (pan_col < pw) && (col_tgt >= col_src) && (col_tgt < col_src + pw);
		row_hit = (pan_row < ph) && (row_tgt >= row_src) && (row_tgt < row_src + ph);

		if (col_hit && row_hit) begin
			rb = chan_byte(d[15:0]);
			gb = chan_byte(d[31:16]);
			bb = chan_byte(d[47:32]);
			for (int k = 0; k < 4; k++) begin
				pnl      = panel_t'(k);
				px.col   = COL_W'(pan_col + k * pw);
				px.row   = pan_row;
				px.red   = (pnl == PANEL_RGB || pnl == PANEL_RED)   ? rb : '0;
				px.green = (pnl == PANEL_RGB || pnl == PANEL_GREEN) ? gb : '0;
				px.blue  = (pnl == PANEL_RGB || pnl == PANEL_BLUE)  ? bb : '0;
				px.last  = (pnl == PANEL_BLUE);
				pixels_due.push_back(px);
			end
		end

		if (col_hit) begin
			pan_col = pan_col + 1'b1;
			col_tgt = col_tgt + ACC_W'(w);
		end
		if (src_col + 1 < w) begin
			src_col = src_col + 1'b1;
			col_src = col_src + ACC_W'(pw);
		end else begin
			// wrap to the next source row
			src_col = '0;
			col_src = '0;
			pan_col = '0;
			col_tgt = '0;
			if (row_hit) begin
				pan_row = pan_row + 1'b1;
				row_tgt = row_tgt + ACC_W'(h);
			end
			if (src_row + 1 < h) begin
				src_row = src_row + 1'b1;
				row_src = row_src + ACC_W'(ph);
			end else begin
				restart_frame();
			end
		end
	endtask

	task automatic check_field(input string what, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, what, want, got);
			errors++;
		end
	endtask

	// Compare one output word with the oldest pixel due
	task automatic check_pixel();
		preview_px_t px;
		if (pixels_due.size() == 0) begin
			$display("%0t: pixel col %0d row %0d arrived with none due", $time,
				m_tdata[11:0], m_tdata[21:12]);
			errors++;
		end else begin
			px = pixels_due.pop_front();
			check_field("out_col",     px.col,   m_tdata[11:0]);
			check_field("out_row",     px.row,   m_tdata[21:12]);
			check_field("red_byte",    px.red,   m_tdata[29:22]);
			check_field("green_byte",  px.green, m_tdata[37:30]);
			check_field("blue_byte",   px.blue,  m_tdata[45:38]);
			check_field("zero fill",   0,        m_tdata[47:46]);
			check_field("last_of_run", px.last,  m_tlast);
		end
	endtask

	// Watch the write port and both streams
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_tw = TDIM_W'(224);
			reg_th = TDIM_W'(224);
			reg_pw = PDIM_W'(224);
			reg_ph = PDIM_W'(224);
			restart_frame();
			pixels_due.delete();
			errors = 0;
			pending <= 0;
			fail_count <= 0;
		end else begin
			if (m_tvalid && m_tready)
				check_pixel();
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_TENSOR_WIDTH:  reg_tw = cfg_wdata[TDIM_W-1:0];
					REG_TENSOR_HEIGHT: reg_th = cfg_wdata[TDIM_W-1:0];
					REG_PANEL_WIDTH:   reg_pw = cfg_wdata[PDIM_W-1:0];
					REG_PANEL_HEIGHT:  reg_ph = cfg_wdata[PDIM_W-1:0];
					default: ;
				endcase
				restart_frame();
			end
			if (s_tvalid && s_tready)
				scan_position(s_tdata);
			pending <= pixels_due.size();
			fail_count <= errors;
		end
	end

endmodule

>>> tb/tb_top.sv
// Top of the tensor channel preview testbench: clock, reset, register writes,
// tensor word stimulus, output back-pressure and the verdict.
// Depends on tcp_pkg, tensor_channel_preview and tcp_checker.
`timescale 1ns / 1ps

module tb_top;
	import tcp_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int RX_HOLD_CYCLES = 80;
	localparam int RANDOM_WORDS   = 262;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [CIDX_W-1:0]  cfg_index;
	logic [CFG_W-1:0]   cfg_wdata;
	logic               s_tvalid;
	logic               s_tready;
	logic [SDATA_W-1:0] s_tdata;
	logic               m_tvalid;
	logic               m_tready;
	logic [MDATA_W-1:0] m_tdata;
	logic               m_tlast;

	int   pending;
	int   fail_count;
	int   tx_idle_pct = 0;
	int   rx_idle_pct = 0;
	logic hold_rx = 1'b0;
	int   idle_cycles = 0;

	tensor_channel_preview dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	tcp_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.pending    (pending),
		.fail_count (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Receiver: random back-pressure, or a long hold-off on request
	initial begin
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_rx) begin
				m_tready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
				hold_rx <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	// Abort when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
				idle_cycles <= 0;
			else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_top: FAIL");
				$finish;
			end else
				idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic logic [SDATA_W-1:0] pack_word(input logic [VAL_W-1:0] r,
			input logic [VAL_W-1:0] g, input logic [VAL_W-1:0] b);
		return {b, g, r};
	endfunction

	// Channel value biased towards the rounding and saturation edges
	function automatic logic [VAL_W-1:0] rand_chan();
		case ($urandom_range(0, 3))
			0: return VAL_W'($urandom);
			1: return VAL_W'($urandom_range(0, 4200));
			2: return VAL_W'($urandom_range(4076, 4110));
			default: return VAL_W'(int'($urandom_range(0, 32)) - 16);
		endcase
	endfunction

	// Offer one word, with a random gap in front, and hold it until taken
	task automatic send_word(input logic [SDATA_W-1:0] w);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= w;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic send_random(input int unsigned n);
		repeat (n)
			send_word(pack_word(rand_chan(), rand_chan(), rand_chan()));
	endtask

	// Drop valid and wait until every pixel due has gone out, plus the scan latency
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_geometry(input int unsigned tw, input int unsigned th,
			input int unsigned pw, input int unsigned ph);
		cfg_we    <= 1'b1;
		cfg_index <= REG_TENSOR_WIDTH;
		cfg_wdata <= CFG_W'(tw);
		@(posedge clk);
		cfg_index <= REG_TENSOR_HEIGHT;
		cfg_wdata <= CFG_W'(th);
		@(posedge clk);
		cfg_index <= REG_PANEL_WIDTH;
		cfg_wdata <= CFG_W'(pw);
		@(posedge clk);
		cfg_index <= REG_PANEL_HEIGHT;
		cfg_wdata <= CFG_W'(ph);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Pick a random dimension: mostly small, now and then zero or oversized
	function automatic int unsigned rand_dim(input int unsigned hi);
		case ($urandom_range(0, 19))
			0: return 0;
			1: return 8191;
			default: return $urandom_range(1, hi);
		endcase
	endfunction

	function automatic int unsigned used_dim(input int unsigned v, input int unsigned hi);
		return (v == 0) ? 1 : ((v > hi) ? hi : v);
	endfunction

	function automatic int unsigned rand_panel(input int unsigned t_used);
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 1023;
			2: return t_used + $urandom_range(1, 3);
			default: return $urandom_range(1, (t_used > 640) ? 640 : t_used);
		endcase
	endfunction

	// Stimulus
	initial begin
		int unsigned tw, th, pw, ph, wu, hu, n, rand_sent;
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= REG_TENSOR_WIDTH;
		cfg_wdata <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 29;
		rx_idle_pct = 72;

		// Reset geometry: every position of the first row is picked
		send_word(pack_word(16'h8000, 16'h7FFF, 16'h0000));
		send_word(pack_word(16'd4096, 16'd2048, 16'hFFF8));
		send_word(pack_word(16'hFFF7, 16'd4088, 16'd4080));
		send_word(pack_word(16'd4104, 16'd4105, 16'hFFFF));
		send_word(pack_word(16'd8, 16'd9, 16'h7FF0));
		send_word(pack_word(16'h5555, 16'hAAAA, 16'h1234));
		drain();

		// Zero dimensions: a one-position frame, wrapping on every word
		set_geometry(0, 0, 0, 0);
		send_random(3);
		drain();

		// Oversized dimensions, clamped to the maximum tensor and panel sizes
		set_geometry(8191, 2, 1023, 2);
		send_random(8);
		drain();

		// Panel larger than the tensor, across a frame boundary
		set_geometry(3, 2, 10, 5);
		send_random(7);
		drain();

		// Receiver holds off while the sender keeps offering, then the sender pauses
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		set_geometry(6, 4, 6, 4);
		hold_rx <= 1'b1;
		send_random(12);
		drain();
		send_random(12);
		drain();

		// Random geometries: small ones get whole frames and maybe a part, others a part
		rand_sent = 0;
		while (rand_sent < RANDOM_WORDS) begin
			if (rand_sent < RANDOM_WORDS / 3) begin
				tx_idle_pct = 29;
				rx_idle_pct = 72;
			end else if (rand_sent < 2 * RANDOM_WORDS / 3) begin
				tx_idle_pct = 72;
				rx_idle_pct = 29;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			tw = rand_dim(10);
			th = rand_dim(5);
			wu = used_dim(tw, MAX_TENSOR_DIM);
			hu = used_dim(th, MAX_TENSOR_DIM);
			pw = rand_panel(wu);
			ph = rand_panel(hu);
			if (wu * hu <= 40)
				n = wu * hu * $urandom_range(1, 2) + $urandom_range(0, 3);
			else
				n = $urandom_range(10, 30);
			if (n > RANDOM_WORDS - rand_sent)
				n = RANDOM_WORDS - rand_sent;
			set_geometry(tw, th, pw, ph);
			send_random(n);
			rand_sent += n;
			drain();
		end

		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

>>> files.f
sv/tcp_pkg.sv
sv/tcp_scan.sv
sv/tensor_channel_preview.sv
tb/tcp_checker.sv
tb/tb_top.sv
